// ===== rtl/stt_pkg.sv =====
package stt_pkg;

  localparam int MAX_FILE_BYTES = 65536;
  localparam int POS_W = $clog2(MAX_FILE_BYTES);
  localparam int MAX_RES = 4;
  localparam int QUEUE_DEPTH = 4;

  // scanner modes
  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_OP        = 3'd1;
  localparam logic [2:0] MODE_NUM       = 3'd2;
  localparam logic [2:0] MODE_IDENT     = 3'd3;
  localparam logic [2:0] MODE_STR       = 3'd4;
  localparam logic [2:0] MODE_LINE_COM  = 3'd5;
  localparam logic [2:0] MODE_BLOCK_COM = 3'd6;

  // token kinds
  localparam logic [5:0] TK_NONE      = 6'd0;
  localparam logic [5:0] TK_INC       = 6'd0;
  localparam logic [5:0] TK_DEC       = 6'd3;
  localparam logic [5:0] TK_BACKSLASH = 6'd31;
  localparam logic [5:0] TK_DOT       = 6'd32;
  localparam logic [5:0] TK_STRING    = 6'd34;
  localparam logic [5:0] TK_INT       = 6'd35;
  localparam logic [5:0] TK_DOUBLE    = 6'd36;
  localparam logic [5:0] TK_IDENT     = 6'd37;
  localparam logic [5:0] TK_NEWLINE   = 6'd38;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHAR     = 2'd1;
  localparam logic [1:0] ERR_STRING   = 2'd2;
  localparam logic [1:0] ERR_COMMENT  = 2'd3;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [16:0] line;
    logic [15:0] col;
    logic [15:0] start;
    logic [16:0] len;
  } res_t;

  typedef struct packed {
    logic [2:0]           cnt;
    res_t [MAX_RES-1:0]   r;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_ident_start(c) || c == "-";
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "!" ||
           c == "=" || c == "^" || c == ">" || c == "<" || c == ".";
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+":     k = 6'd2;
      "-":     k = 6'd5;
      "*":     k = 6'd7;
      "/":     k = 6'd9;
      "%":     k = 6'd11;
      "!":     k = 6'd13;
      "=":     k = 6'd15;
      "^":     k = 6'd17;
      ">":     k = 6'd19;
      "<":     k = 6'd21;
      default: k = TK_DOT;
    endcase
    return k;
  endfunction

  function automatic logic is_plain(input logic [7:0] c);
    return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" || c == "]" ||
           c == "?" || c == ":" || c == ";" || c == ",";
  endfunction

  function automatic logic [5:0] plain_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(":     k = 6'd22;
      ")":     k = 6'd23;
      "{":     k = 6'd24;
      "}":     k = 6'd25;
      "[":     k = 6'd26;
      "]":     k = 6'd27;
      "?":     k = 6'd28;
      ":":     k = 6'd29;
      ";":     k = 6'd30;
      default: k = 6'd33;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] col_of(input logic [16:0] pos, input logic [16:0] lst);
    logic [16:0] d;
    d = pos - lst;
    return d[15:0];
  endfunction

  function automatic res_t mk_res(input logic [5:0] kind, input logic [1:0] err,
                                  input logic [16:0] line, input logic [15:0] col,
                                  input logic [16:0] start, input logic [16:0] len);
    res_t r;
    r.kind  = kind;
    r.err   = err;
    r.line  = line;
    r.col   = col;
    r.start = start[15:0];
    r.len   = len;
    return r;
  endfunction

  function automatic bundle_t put(input bundle_t b, input res_t r);
    bundle_t o;
    o = b;
    if (o.cnt < 3'(MAX_RES)) begin
      o.r[o.cnt[1:0]] = r;
      o.cnt = o.cnt + 3'd1;
    end
    return o;
  endfunction

endpackage

// ===== rtl/stt_front.sv =====
module stt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      char_byte,
  input  logic            end_of_file,
  output stt_pkg::bundle_t bnd,
  output logic            bnd_valid
);
  import stt_pkg::*;

  logic [2:0]       mode, mode_next;
  logic [7:0]       held, held_next;
  logic [7:0]       quote, quote_next;
  logic [POS_W-1:0] pos;
  logic [16:0]      tstart, tstart_next;
  logic [16:0]      line_cnt, line_cnt_next;
  logic [16:0]      line_st, line_st_next;
  logic             dot, dot_next;
  logic             bs, bs_next;
  logic             last_nl, last_nl_next;
  logic             any_tok, any_tok_next;
  logic [15:0]      ccol, ccol_next;
  logic [16:0]      cline, cline_next;
  logic             star, star_next;
  logic [16:0]      bs_line, bs_line_next;
  logic [15:0]      bs_col, bs_col_next;
  logic [16:0]      bs_start, bs_start_next;

  logic [16:0] p, p_end;
  logic        finish, do_disp, tk_v;
  logic [5:0]  tk_kind;
  logic [15:0] tk_col;
  logic [16:0] tk_start, tk_len;
  bundle_t     b;

  assign p      = 17'(pos);
  assign p_end  = p + 17'd1;
  assign finish = end_of_file || pos == POS_W'(MAX_FILE_BYTES - 1);

  always_comb begin
    mode_next = mode; held_next = held; quote_next = quote; tstart_next = tstart;
    line_cnt_next = line_cnt; line_st_next = line_st; dot_next = dot; bs_next = bs;
    last_nl_next = last_nl; any_tok_next = any_tok; ccol_next = ccol; cline_next = cline;
    star_next = star; bs_line_next = bs_line; bs_col_next = bs_col;
    bs_start_next = bs_start;
    b = '0;
    do_disp = 1'b0;
    tk_v = 1'b0; tk_kind = TK_NONE; tk_col = '0; tk_start = '0; tk_len = '0;

    // continue the pending token
    case (mode)
      MODE_OP: begin
        if (held == "+" && char_byte == "+") begin
          tk_v = 1'b1; tk_kind = TK_INC; tk_len = 17'd2;
          mode_next = MODE_IDLE;
        end else if (held == "-" && char_byte == "-") begin
          tk_v = 1'b1; tk_kind = TK_DEC; tk_len = 17'd2;
          mode_next = MODE_IDLE;
        end else if (char_byte == "=" && held != ".") begin
          tk_v = 1'b1; tk_kind = op_kind(held) - 6'd1; tk_len = 17'd2;
          mode_next = MODE_IDLE;
        end else if (held == "/" && char_byte == "/") begin
          mode_next = MODE_LINE_COM;
        end else if (held == "/" && char_byte == "*") begin
          mode_next = MODE_BLOCK_COM;
          ccol_next = col_of(tstart, line_st);
          cline_next = line_cnt;
          star_next = 1'b0;
        end else if (held == "." && is_digit(char_byte)) begin
          mode_next = MODE_NUM;
          dot_next = 1'b1;
        end else begin
          tk_v = 1'b1; tk_kind = op_kind(held); tk_len = 17'd1;
          do_disp = 1'b1;
        end
        tk_col = col_of(tstart, line_st);
        tk_start = tstart;
      end
      MODE_NUM: begin
        if (is_digit(char_byte) || char_byte == ".") begin
          if (char_byte == ".") dot_next = 1'b1;
        end else begin
          tk_v = 1'b1; tk_kind = dot ? TK_DOUBLE : TK_INT;
          tk_col = col_of(tstart, line_st); tk_start = tstart; tk_len = p - tstart;
          do_disp = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!is_ident_char(char_byte)) begin
          tk_v = 1'b1; tk_kind = TK_IDENT;
          tk_col = col_of(tstart, line_st); tk_start = tstart; tk_len = p - tstart;
          do_disp = 1'b1;
        end
      end
      MODE_STR: begin
        if (char_byte == quote) begin
          tk_v = 1'b1; tk_kind = TK_STRING;
          tk_col = col_of(p, line_st); tk_start = tstart; tk_len = p - tstart;
          mode_next = MODE_IDLE;
        end
      end
      MODE_LINE_COM: begin
        if (char_byte == "\n") do_disp = 1'b1;
      end
      MODE_BLOCK_COM: begin
        if (star && char_byte == "/") begin
          mode_next = MODE_IDLE;
        end else begin
          if (char_byte == "\n") begin
            line_cnt_next = line_cnt + 17'd1;
            line_st_next = p_end;
          end
          star_next = char_byte == "*";
        end
      end
      default: do_disp = 1'b1;
    endcase

    if (tk_v) begin
      if (bs_next) begin
        b = put(b, mk_res(TK_BACKSLASH, ERR_NONE, bs_line_next, bs_col_next,
                          bs_start_next, 17'd1));
        bs_next = 1'b0;
      end
      b = put(b, mk_res(tk_kind, ERR_NONE, line_cnt_next, tk_col, tk_start, tk_len));
      any_tok_next = 1'b1;
      last_nl_next = 1'b0;
    end

    // start something new with this byte
    if (do_disp) begin
      mode_next = MODE_IDLE;
      if (char_byte == " " || char_byte == "\t" || char_byte == "\r" ||
          char_byte == 8'h0b || char_byte == 8'h0c) begin
        mode_next = MODE_IDLE;
      end else if (char_byte == "\n") begin
        if (bs_next) begin
          bs_next = 1'b0;
        end else if (any_tok_next && !last_nl_next) begin
          b = put(b, mk_res(TK_NEWLINE, ERR_NONE, line_cnt_next,
                            col_of(p, line_st_next), p, 17'd1));
          any_tok_next = 1'b1;
          last_nl_next = 1'b1;
        end
        line_cnt_next = line_cnt_next + 17'd1;
        line_st_next = p_end;
      end else if (char_byte == "\\") begin
        if (bs_next) begin
          b = put(b, mk_res(TK_BACKSLASH, ERR_NONE, bs_line_next, bs_col_next,
                            bs_start_next, 17'd1));
          any_tok_next = 1'b1;
          last_nl_next = 1'b0;
        end
        bs_next = 1'b1;
        bs_line_next = line_cnt_next;
        bs_col_next = col_of(p, line_st_next);
        bs_start_next = p;
      end else if (char_byte == "'" || char_byte == "\"") begin
        mode_next = MODE_STR;
        quote_next = char_byte;
        tstart_next = p_end;
      end else if (is_op(char_byte)) begin
        mode_next = MODE_OP;
        held_next = char_byte;
        tstart_next = p;
      end else if (is_plain(char_byte)) begin
        if (bs_next) begin
          b = put(b, mk_res(TK_BACKSLASH, ERR_NONE, bs_line_next, bs_col_next,
                            bs_start_next, 17'd1));
          bs_next = 1'b0;
        end
        b = put(b, mk_res(plain_kind(char_byte), ERR_NONE, line_cnt_next,
                          col_of(p, line_st_next), p, 17'd1));
        any_tok_next = 1'b1;
        last_nl_next = 1'b0;
      end else if (is_digit(char_byte)) begin
        mode_next = MODE_NUM;
        dot_next = 1'b0;
        tstart_next = p;
      end else if (is_ident_start(char_byte)) begin
        mode_next = MODE_IDENT;
        tstart_next = p;
      end else begin
        b = put(b, mk_res(TK_NONE, ERR_CHAR, line_cnt_next, col_of(p, line_st_next),
                          p, 17'd0));
      end
    end

    // end of file closes what is open
    if (finish) begin
      tk_v = 1'b0;
      case (mode_next)
        MODE_OP: begin
          tk_v = 1'b1; tk_kind = op_kind(held_next); tk_len = 17'd1;
        end
        MODE_NUM: begin
          tk_v = 1'b1; tk_kind = dot_next ? TK_DOUBLE : TK_INT; tk_len = p_end - tstart_next;
        end
        MODE_IDENT: begin
          tk_v = 1'b1; tk_kind = TK_IDENT; tk_len = p_end - tstart_next;
        end
        MODE_STR: begin
          b = put(b, mk_res(TK_NONE, ERR_STRING, line_cnt_next,
                            col_of(tstart_next - 17'd1, line_st_next),
                            tstart_next - 17'd1, 17'd0));
        end
        MODE_BLOCK_COM: begin
          b = put(b, mk_res(TK_NONE, ERR_COMMENT, cline_next, ccol_next,
                            tstart_next, 17'd0));
        end
        default: tk_v = 1'b0;
      endcase
      if (tk_v) begin
        if (bs_next) begin
          b = put(b, mk_res(TK_BACKSLASH, ERR_NONE, bs_line_next, bs_col_next,
                            bs_start_next, 17'd1));
          bs_next = 1'b0;
        end
        b = put(b, mk_res(tk_kind, ERR_NONE, line_cnt_next,
                          col_of(tstart_next, line_st_next), tstart_next, tk_len));
      end
      if (bs_next) begin
        b = put(b, mk_res(TK_BACKSLASH, ERR_NONE, bs_line_next, bs_col_next,
                          bs_start_next, 17'd1));
      end
    end
  end

  assign bnd       = b;
  assign bnd_valid = accept && b.cnt != 3'd0;

  always_ff @(posedge clk) begin
    if (rst || (accept && finish)) begin
      mode <= MODE_IDLE; held <= '0; quote <= '0; pos <= '0; tstart <= '0;
      line_cnt <= 17'd1; line_st <= '0; dot <= 1'b0; bs <= 1'b0; last_nl <= 1'b0;
      any_tok <= 1'b0; ccol <= '0; cline <= '0; star <= 1'b0;
      bs_line <= '0; bs_col <= '0; bs_start <= '0;
    end else if (accept) begin
      mode <= mode_next; held <= held_next; quote <= quote_next; pos <= pos + 1'b1;
      tstart <= tstart_next; line_cnt <= line_cnt_next; line_st <= line_st_next;
      dot <= dot_next; bs <= bs_next; last_nl <= last_nl_next; any_tok <= any_tok_next;
      ccol <= ccol_next; cline <= cline_next; star <= star_next;
      bs_line <= bs_line_next; bs_col <= bs_col_next; bs_start <= bs_start_next;
    end
  end

endmodule

// ===== rtl/stt_back.sv =====
module stt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  stt_pkg::bundle_t wr_bnd,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output stt_pkg::res_t    head,
  output logic             head_last
);
  import stt_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  bundle_t       q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic [1:0]    idx;
  logic          rd, wr_en;
  bundle_t       hb;

  assign hb        = q[rd_ptr];
  assign empty     = count == '0;
  assign full      = count == (AW+1)'(QUEUE_DEPTH);
  assign head      = hb.r[idx];
  assign head_last = 3'(idx) + 3'd1 == hb.cnt;
  assign rd        = pop && !empty && head_last;
  assign wr_en     = wr && !full;

  always_ff @(posedge clk) begin
    if (wr_en) q[wr_ptr] <= wr_bnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      idx    <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
        idx    <= '0;
      end else if (pop && !empty) begin
        idx <= idx + 2'd1;
      end
      case ({wr_en, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// channel   direction  handshake          payload
// input     in         push / full        char_byte, end_of_file
// result    out        empty / pop        token_kind, error_code, line_number, column,
//                                         text_start, text_length, last_result
//
// one byte per cycle while full is low; each request is scanned in the cycle it is accepted
// results of a byte go as one bundle into a four-deep queue, drained one per pop
// full rises only when the queue holds four bundles with results
// rst is synchronous and clears the scanner state and the queue
// a byte with end_of_file, or byte 65536, ends the file and restarts the scanner
module source_text_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte,
  input  logic        end_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  token_kind,
  output logic [1:0]  error_code,
  output logic [16:0] line_number,
  output logic [15:0] column,
  output logic [15:0] text_start,
  output logic [16:0] text_length,
  output logic        last_result
);
  import stt_pkg::*;

  logic    accept;
  bundle_t bnd;
  logic    bnd_valid;
  res_t    head;

  // a byte is taken whenever the queue has room for its results
  assign accept = push && !full;

  // front: scanner state machine
  stt_front u_front (
    .clk,
    .rst,
    .accept,
    .char_byte,
    .end_of_file,
    .bnd,
    .bnd_valid
  );

  // back: result queue and serializer
  stt_back u_back (
    .clk,
    .rst,
    .wr        (bnd_valid),
    .wr_bnd    (bnd),
    .pop,
    .full,
    .empty,
    .head,
    .head_last (last_result)
  );

  assign token_kind  = head.kind;
  assign error_code  = head.err;
  assign line_number = head.line;
  assign column      = head.col;
  assign text_start  = head.start;
  assign text_length = head.len;

  // a byte never causes more than four results
  a_bundle_size: assert property (@(posedge clk) disable iff (rst)
    bnd_valid |-> bnd.cnt <= 3'd4) else $error("bundle too large");

  // error results carry no kind and no length
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && error_code != ERR_NONE) |-> (token_kind == TK_NONE && text_length == 17'd0))
    else $error("malformed error result");

  // reset empties the queue
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("queue not empty after reset");

endmodule
